// ===== src/fsts_pkg.sv =====
// shared types and lookup functions for the fair-share tick scheduler
// depends on nothing; used by fsts_pick and fair_share_tick_scheduler
package fsts_pkg;

  localparam int unsigned NiceW  = 6;
  localparam int unsigned DeltaW = 7;

  typedef struct packed {
    logic [31:0]      arrival;
    logic [15:0]      remaining;
    logic [NiceW-1:0] nice;
    logic [63:0]      vruntime;
  } slot_rec_t;

  typedef struct packed {
    logic clr;   // start of a new scan
    logic vld;   // slot record on the read port is valid
  } pick_ctl_t;

  // priority clamped to 1..10, nice index (p-1)*39/9
  function automatic logic [NiceW-1:0] nice_of(input logic [3:0] prio);
    logic [NiceW-1:0] n;
    case (prio) inside
      4'd0, 4'd1: n = 6'd0;
      4'd2:       n = 6'd4;
      4'd3:       n = 6'd8;
      4'd4:       n = 6'd13;
      4'd5:       n = 6'd17;
      4'd6:       n = 6'd21;
      4'd7:       n = 6'd26;
      4'd8:       n = 6'd30;
      4'd9:       n = 6'd34;
      default:    n = 6'd39;
    endcase
    return n;
  endfunction

  // (1024 * inverse weight) >> 32; nice-0 weight gives 1
  function automatic logic [DeltaW-1:0] delta_of(input logic [NiceW-1:0] idx);
    logic [DeltaW-1:0] d;
    case (idx) inside
      [6'd0:6'd19]:  d = 7'd0;
      [6'd20:6'd23]: d = 7'd1;
      6'd24:         d = 7'd2;
      6'd25, 6'd26:  d = 7'd3;
      6'd27:         d = 7'd4;
      6'd28:         d = 7'd5;
      6'd29:         d = 7'd7;
      6'd30:         d = 7'd9;
      6'd31:         d = 7'd11;
      6'd32:         d = 7'd14;
      6'd33:         d = 7'd18;
      6'd34:         d = 7'd22;
      6'd35:         d = 7'd28;
      6'd36:         d = 7'd35;
      6'd37:         d = 7'd44;
      6'd38:         d = 7'd56;
      default:       d = 7'd68;
    endcase
    return d;
  endfunction

endpackage

// ===== src/fsts_pick.sv =====
// running minimum-vruntime selection over slot records streamed from the table
// depends on fsts_pkg
module fsts_pick
  import fsts_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pick_ctl_t        ctl,
  input  logic [IDX_W-1:0] rec_idx,
  input  slot_rec_t        rec,
  input  logic [31:0]      now_time,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output slot_rec_t        best_rec
);

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  slot_rec_t        best_rec_r, best_rec_nxt;
  logic             eligible;

  // arrived means arrival strictly before the current tick
  assign eligible = (rec.remaining != 16'd0) && (rec.arrival < now_time);

  always_comb begin
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_rec_nxt = best_rec_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (ctl.vld && eligible &&
                 (!found_r || (rec.vruntime < best_rec_r.vruntime))) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rec_idx;
      best_rec_nxt = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_idx_r <= best_idx_nxt;
    best_rec_r <= best_rec_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_rec = best_rec_r;

endmodule

// ===== src/fair_share_tick_scheduler.sv =====
// top level of the fair-share tick scheduler: slot table memory and sequencer
// depends on fsts_pkg and fsts_pick
module fair_share_tick_scheduler
  import fsts_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [3:0]  in_priority_req,
  input  logic [31:0] in_arrival_time,
  input  logic [15:0] in_burst_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ran_valid,
  output logic [3:0]  out_ran_slot,
  output logic [31:0] out_tick_time,
  output logic        out_completed,
  output logic        out_all_done,
  output logic        out_add_rejected
);
  // One request at a time. A tick on an empty table skips the scan. The slot
  // table is a single-port-read memory and the scan reads one slot per cycle,
  // followed by a drain state for the read latency, an update state that does
  // the read-modify-write of the chosen slot, and an emit state that loads the
  // result register, which presents the result, once the output is free. A new
  // request is taken while the previous result still waits on the output. Slots
  // fill in order, so the fill count marks which entries are live and the table
  // needs no clearing after reset; the count of unfinished slots gives all_done.

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_UPD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] slot_count_r, slot_count_nxt;
  logic [CNT_W-1:0] live_cnt_r, live_cnt_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_vld_r, rd_vld_nxt;

  logic             res_ran_valid_r, res_ran_valid_nxt;
  logic [3:0]       res_ran_slot_r, res_ran_slot_nxt;
  logic             res_completed_r, res_completed_nxt;
  logic             res_rejected_r, res_rejected_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ran_valid_r;
  logic [3:0]       out_ran_slot_r;
  logic [31:0]      out_tick_time_r;
  logic             out_completed_r;
  logic             out_all_done_r;
  logic             out_add_rejected_r;

  slot_rec_t        slot_mem [MAX_PROCS];
  slot_rec_t        mem_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_rec_t        wr_data;

  pick_ctl_t        pick_ctl;
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;
  slot_rec_t        pick_rec;

  logic             accept;
  logic             table_full;
  logic             last_read;
  logic             out_free;
  logic [15:0]      rem_dec;

  assign accept     = in_valid && in_ready;
  assign table_full = (slot_count_r == CNT_W'(MAX_PROCS));
  assign last_read  = (CNT_W'(rd_ptr_r) == (slot_count_r - CNT_W'(1)));
  assign out_free   = !out_valid_r || out_ready;
  assign rem_dec    = pick_rec.remaining - 16'd1;
  assign in_ready   = (state_r == S_IDLE);

  fsts_pick #(
    .IDX_W(IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .rec_idx  (rd_idx_r),
    .rec      (mem_q),
    .now_time (now_r),
    .found    (pick_found),
    .best_idx (pick_idx),
    .best_rec (pick_rec)
  );

  always_comb begin
    state_nxt         = state_r;
    slot_count_nxt    = slot_count_r;
    live_cnt_nxt      = live_cnt_r;
    now_nxt           = now_r;
    rd_ptr_nxt        = rd_ptr_r;
    rd_vld_nxt        = 1'b0;
    res_ran_valid_nxt = res_ran_valid_r;
    res_ran_slot_nxt  = res_ran_slot_r;
    res_completed_nxt = res_completed_r;
    res_rejected_nxt  = res_rejected_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    pick_ctl.clr      = 1'b0;
    pick_ctl.vld      = rd_vld_r;
    wr_en             = 1'b0;
    wr_addr           = slot_count_r[IDX_W-1:0];
    wr_data.arrival   = in_arrival_time;
    wr_data.remaining = in_burst_ticks;
    wr_data.nice      = nice_of(in_priority_req);
    wr_data.vruntime  = 64'd0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_ran_valid_nxt = 1'b0;
          res_ran_slot_nxt  = 4'd0;
          res_completed_nxt = 1'b0;
          res_rejected_nxt  = 1'b0;
          if (!in_func) begin
            if (table_full) begin
              res_rejected_nxt = 1'b1;
            end else begin
              wr_en          = 1'b1;
              slot_count_nxt = slot_count_r + CNT_W'(1);
              if (in_burst_ticks != 16'd0) begin
                live_cnt_nxt = live_cnt_r + CNT_W'(1);
              end
            end
            state_nxt = S_EMIT;
          end else begin
            now_nxt      = now_r + 32'd1;
            pick_ctl.clr = 1'b1;
            rd_ptr_nxt   = '0;
            state_nxt    = (slot_count_r == '0) ? S_EMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (last_read) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_ptr_nxt = rd_ptr_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (pick_found) begin
          wr_en             = 1'b1;
          wr_addr           = pick_idx;
          wr_data           = pick_rec;
          wr_data.remaining = rem_dec;
          wr_data.vruntime  = pick_rec.vruntime + 64'(delta_of(pick_rec.nice));
          res_ran_valid_nxt = 1'b1;
          res_ran_slot_nxt  = 4'(pick_idx);
          if (rem_dec == 16'd0) begin
            res_completed_nxt = 1'b1;
            live_cnt_nxt      = live_cnt_r - CNT_W'(1);
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // slot table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    mem_q    <= slot_mem[rd_ptr_r];
    rd_idx_r <= rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= '0;
      live_cnt_r   <= '0;
      now_r        <= 32'd0;
      rd_ptr_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      live_cnt_r   <= live_cnt_nxt;
      now_r        <= now_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ran_valid_r <= res_ran_valid_nxt;
    res_ran_slot_r  <= res_ran_slot_nxt;
    res_completed_r <= res_completed_nxt;
    res_rejected_r  <= res_rejected_nxt;
    if ((state_r == S_EMIT) && out_free) begin
      out_ran_valid_r    <= res_ran_valid_r;
      out_ran_slot_r     <= res_ran_slot_r;
      out_tick_time_r    <= now_r;
      out_completed_r    <= res_completed_r;
      out_all_done_r     <= (live_cnt_r == '0);
      out_add_rejected_r <= res_rejected_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ran_valid    = out_ran_valid_r;
  assign out_ran_slot     = out_ran_slot_r;
  assign out_tick_time    = out_tick_time_r;
  assign out_completed    = out_completed_r;
  assign out_all_done     = out_all_done_r;
  assign out_add_rejected = out_add_rejected_r;

endmodule

// ===== tb/sv/pick_scoreboard_pkg.sv =====
// scoreboard for the fair-share tick scheduler testbench: slot table predictor and result check
// standalone package, used by tb_top
package pick_scoreboard_pkg;

  localparam int unsigned SLOTS        = 16;
  localparam logic        FUNC_ADD     = 1'b0;
  localparam logic        FUNC_TICK    = 1'b1;
  localparam int unsigned NICE_ZERO_IX = 20;

  // inverse weights, 2^32 / weight
  localparam int unsigned INV_WEIGHT [40] = '{
    48388, 59856, 76040, 92818, 118348,
    147320, 184698, 229616, 287308, 360437,
    449829, 563644, 704093, 875809, 1099582,
    1376151, 1717300, 2157191, 2708050, 3363326,
    4194304, 5237765, 6557202, 8165337, 10153587,
    12820798, 15790321, 19976592, 24970740, 31350126,
    39045157, 49367440, 61356676, 76695844, 95443717,
    119304647, 148102320, 186737708, 238609294, 286331153
  };

  typedef struct packed {
    logic        ran_valid;
    logic [3:0]  ran_slot;
    logic [31:0] tick_time;
    logic        completed;
    logic        all_done;
    logic        add_rejected;
  } pick_result_t;

  class pick_scoreboard;
    bit          slot_used [SLOTS];
    logic [31:0] arrival   [SLOTS];
    logic [15:0] remaining [SLOTS];
    logic [5:0]  nice_ix   [SLOTS];
    logic [63:0] vruntime  [SLOTS];
    logic [31:0] now_time;
    int unsigned slot_count;
    pick_result_t expected_picks[$];
    int errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        arrival[i]   = '0;
        remaining[i] = '0;
        nice_ix[i]   = '0;
        vruntime[i]  = '0;
      end
      now_time   = '0;
      slot_count = 0;
      errors     = 0;
    endfunction

    function automatic logic [5:0] nice_index(input logic [3:0] prio);
      int unsigned p;
      p = prio;
      if (p < 1) p = 1;
      if (p > 10) p = 10;
      return 6'(((p - 1) * 39) / 9);
    endfunction

    function automatic logic [63:0] vruntime_step(input logic [5:0] ix);
      if (ix == NICE_ZERO_IX) return 64'd1;
      return (64'd1024 * 64'(INV_WEIGHT[ix])) >> 32;
    endfunction

    function void note_request(input logic func, input logic [3:0] prio,
                               input logic [31:0] arr, input logic [15:0] burst);
      pick_result_t r;
      bit          found;
      int unsigned best;
      logic [63:0] best_vr;
      r = '0;
      if (func == FUNC_ADD) begin
        if (slot_count >= SLOTS) begin
          r.add_rejected = 1'b1;
        end else begin
          slot_used[slot_count] = 1'b1;
          arrival[slot_count]   = arr;
          remaining[slot_count] = burst;
          nice_ix[slot_count]   = nice_index(prio);
          vruntime[slot_count]  = '0;
          slot_count++;
        end
      end else begin
        found   = 1'b0;
        best    = 0;
        best_vr = '0;
        now_time = now_time + 32'd1;
        // least vruntime among arrived, unfinished slots; lowest index on ties
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && remaining[i] != 0 && arrival[i] < now_time) begin
            if (!found || vruntime[i] < best_vr) begin
              found   = 1'b1;
              best    = i;
              best_vr = vruntime[i];
            end
          end
        end
        if (found) begin
          r.ran_valid     = 1'b1;
          r.ran_slot      = 4'(best);
          remaining[best] = remaining[best] - 16'd1;
          vruntime[best]  = vruntime[best] + vruntime_step(nice_ix[best]);
          r.completed     = (remaining[best] == 0);
        end
      end
      r.tick_time = now_time;
      r.all_done  = 1'b1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && remaining[i] != 0) r.all_done = 1'b0;
      expected_picks.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_pick(input pick_result_t got);
      pick_result_t want;
      if (expected_picks.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, got);
        return;
      end
      want = expected_picks.pop_front();
      compare_field("ran_valid", 32'(want.ran_valid), 32'(got.ran_valid));
      compare_field("ran_slot", 32'(want.ran_slot), 32'(got.ran_slot));
      compare_field("tick_time", want.tick_time, got.tick_time);
      compare_field("completed", 32'(want.completed), 32'(got.completed));
      compare_field("all_done", 32'(want.all_done), 32'(got.all_done));
      compare_field("add_rejected", 32'(want.add_rejected), 32'(got.add_rejected));
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// top of the fair-share tick scheduler testbench: clock, reset, request driver and receiver
// depends on pick_scoreboard_pkg and the scheduler rtl
module tb_top;
  import pick_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  localparam int READY_FREE   = 0;
  localparam int READY_CHOPPY = 1;
  localparam int READY_SPARSE = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [3:0]  in_priority_req;
  logic [31:0] in_arrival_time;
  logic [15:0] in_burst_ticks;
  logic        out_valid;
  logic        out_ready;
  logic        out_ran_valid;
  logic [3:0]  out_ran_slot;
  logic [31:0] out_tick_time;
  logic        out_completed;
  logic        out_all_done;
  logic        out_add_rejected;

  pick_scoreboard sb;
  int rdy_len;
  int rdy_mode;

  fair_share_tick_scheduler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_priority_req  (in_priority_req),
    .in_arrival_time  (in_arrival_time),
    .in_burst_ticks   (in_burst_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ran_valid    (out_ran_valid),
    .out_ran_slot     (out_ran_slot),
    .out_tick_time    (out_tick_time),
    .out_completed    (out_completed),
    .out_all_done     (out_all_done),
    .out_add_rejected (out_add_rejected)
  );

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_ADD;
    in_priority_req = '0;
    in_arrival_time = '0;
    in_burst_ticks  = '0;
    out_ready       = 1'b0;
    rdy_len         = 0;
    rdy_mode        = READY_FREE;
    sb              = new();
  end

  always #10 clk = ~clk;

  // receiver: free-running, choppy and sparse stretches
  always @(negedge clk) begin
    if (rdy_len == 0) begin
      rdy_mode  <= $urandom_range(READY_FREE, READY_SPARSE);
      rdy_len   <= $urandom_range(5, 50);
      out_ready <= 1'b1;
    end else begin
      rdy_len <= rdy_len - 1;
      case (rdy_mode)
        READY_FREE:   out_ready <= 1'b1;
        READY_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
        default:      out_ready <= (rdy_len % 7 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_func, in_priority_req, in_arrival_time, in_burst_ticks);
    if (rst_n && out_valid && out_ready)
      sb.check_pick('{out_ran_valid, out_ran_slot, out_tick_time,
                      out_completed, out_all_done, out_add_rejected});
  end

  task automatic send_request(input logic func, input logic [3:0] prio,
                              input logic [31:0] arr, input logic [15:0] burst);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_func         <= func;
    in_priority_req <= prio;
    in_arrival_time <= arr;
    in_burst_ticks  <= burst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom,
                 16'($urandom_range(0, 65535)));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  initial begin
    int          adds_sent;
    int          ticks_sent;
    int          burst_left;
    logic [15:0] burst;
    logic [31:0] arr;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: time advances, nothing runs, tick payload ignored
    send_request(FUNC_TICK, 4'hf, 32'hffff_ffff, 16'hffff);
    // clamp low, zero burst that never arrives, clamp high, ties at vruntime zero
    send_request(FUNC_ADD, 4'd0, 32'd0, 16'd2);
    send_request(FUNC_ADD, 4'd10, 32'hffff_ffff, 16'd0);
    send_request(FUNC_ADD, 4'd15, 32'd1, 16'd3);
    send_request(FUNC_ADD, 4'd5, 32'd2, 16'd1);
    send_request(FUNC_ADD, 4'd1, 32'd0, 16'd1);
    send_request(FUNC_ADD, 4'd7, 32'd5, 16'd4);
    repeat (10) send_tick();
    send_request(FUNC_ADD, 4'd9, 32'd0, 16'd5);
    send_request(FUNC_ADD, 4'd8, 32'd11, 16'd3);
    repeat (4) send_tick();
    adds_sent  = 8;
    ticks_sent = 15;
    idle_cycles(3);

    burst_left = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        idle_cycles(($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3));
      end
      burst_left--;
      // let the pipeline drain completely once mid-run
      if (k == 700) begin
        idle_cycles(1);
        while (sb.pending() != 0) @(negedge clk);
      end
      if ((adds_sent < SLOTS && $urandom_range(0, 59) == 0) ||
          (adds_sent >= SLOTS && $urandom_range(0, 14) == 0)) begin
        burst = 16'($urandom_range(1, 40));
        arr   = 32'(ticks_sent) + 32'($urandom_range(0, 25));
        if ($urandom_range(0, 7) == 0) begin
          burst = '0;
          arr   = $urandom;
        end
        // last free slot gets a long burst
        if (adds_sent == SLOTS - 1) burst = 16'($urandom_range(32768, 65535));
        send_request(FUNC_ADD, 4'($urandom_range(0, 15)), arr, burst);
        adds_sent++;
      end else begin
        send_tick();
        ticks_sent++;
      end
    end
    idle_cycles(1);

    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
